>>> src/camb_pkg.sv
// ----------------------------------------------------------------------------
// camb_pkg
// Shared types, constants and round functions of the camellia block cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package camb_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_SIZE   = 3'd4;

    localparam logic [1:0] KEY_SIZE_128 = 2'd0;
    localparam logic [1:0] KEY_SIZE_192 = 2'd1;

    localparam int NUM_ROUNDS = 24;

    localparam logic [63:0] SIGMA1 = 64'ha09e667f3bcc908b;
    localparam logic [63:0] SIGMA2 = 64'hb67ae8584caa73b2;
    localparam logic [63:0] SIGMA3 = 64'hc6ef372fe94f82be;
    localparam logic [63:0] SIGMA4 = 64'h54ff53a5f1d36f1c;
    localparam logic [63:0] SIGMA5 = 64'h10e527fade682d1d;
    localparam logic [63:0] SIGMA6 = 64'hb05688c2b3e6c1fd;

    typedef enum logic [2:0] {
        KS_LOAD,
        KS_F1,
        KS_F2,
        KS_F3,
        KS_F4,
        KS_F5,
        KS_F6,
        KS_READY
    } t_ks_state;

    typedef struct packed {
        logic        mode;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } t_out_item;

    typedef struct packed {
        logic        mode;
        logic [63:0] x;
        logic [63:0] y;
    } t_stage;

    typedef struct packed {
        logic              short_key;
        logic [3:0][63:0]  kw;
        logic [23:0][63:0] rk;
        logic [5:0][63:0]  lk;
    } t_subkeys;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] fl_kx;
        logic [63:0] fl_ky;
        logic        fl_en;
        logic        odd;
        logic        bypass;
    } t_round_ctl;

    localparam logic [7:0] SBOX1 [256] = '{
        8'd112,8'd130,8'd44,8'd236,8'd179,8'd39,8'd192,8'd229,
        8'd228,8'd133,8'd87,8'd53,8'd234,8'd12,8'd174,8'd65,
        8'd35,8'd239,8'd107,8'd147,8'd69,8'd25,8'd165,8'd33,
        8'd237,8'd14,8'd79,8'd78,8'd29,8'd101,8'd146,8'd189,
        8'd134,8'd184,8'd175,8'd143,8'd124,8'd235,8'd31,8'd206,
        8'd62,8'd48,8'd220,8'd95,8'd94,8'd197,8'd11,8'd26,
        8'd166,8'd225,8'd57,8'd202,8'd213,8'd71,8'd93,8'd61,
        8'd217,8'd1,8'd90,8'd214,8'd81,8'd86,8'd108,8'd77,
        8'd139,8'd13,8'd154,8'd102,8'd251,8'd204,8'd176,8'd45,
        8'd116,8'd18,8'd43,8'd32,8'd240,8'd177,8'd132,8'd153,
        8'd223,8'd76,8'd203,8'd194,8'd52,8'd126,8'd118,8'd5,
        8'd109,8'd183,8'd169,8'd49,8'd209,8'd23,8'd4,8'd215,
        8'd20,8'd88,8'd58,8'd97,8'd222,8'd27,8'd17,8'd28,
        8'd50,8'd15,8'd156,8'd22,8'd83,8'd24,8'd242,8'd34,
        8'd254,8'd68,8'd207,8'd178,8'd195,8'd181,8'd122,8'd145,
        8'd36,8'd8,8'd232,8'd168,8'd96,8'd252,8'd105,8'd80,
        8'd170,8'd208,8'd160,8'd125,8'd161,8'd137,8'd98,8'd151,
        8'd84,8'd91,8'd30,8'd149,8'd224,8'd255,8'd100,8'd210,
        8'd16,8'd196,8'd0,8'd72,8'd163,8'd247,8'd117,8'd219,
        8'd138,8'd3,8'd230,8'd218,8'd9,8'd63,8'd221,8'd148,
        8'd135,8'd92,8'd131,8'd2,8'd205,8'd74,8'd144,8'd51,
        8'd115,8'd103,8'd246,8'd243,8'd157,8'd127,8'd191,8'd226,
        8'd82,8'd155,8'd216,8'd38,8'd200,8'd55,8'd198,8'd59,
        8'd129,8'd150,8'd111,8'd75,8'd19,8'd190,8'd99,8'd46,
        8'd233,8'd121,8'd167,8'd140,8'd159,8'd110,8'd188,8'd142,
        8'd41,8'd245,8'd249,8'd182,8'd47,8'd253,8'd180,8'd89,
        8'd120,8'd152,8'd6,8'd106,8'd231,8'd70,8'd113,8'd186,
        8'd212,8'd37,8'd171,8'd66,8'd136,8'd162,8'd141,8'd250,
        8'd114,8'd7,8'd185,8'd85,8'd248,8'd238,8'd172,8'd10,
        8'd54,8'd73,8'd42,8'd104,8'd60,8'd56,8'd241,8'd164,
        8'd64,8'd40,8'd211,8'd123,8'd187,8'd201,8'd67,8'd193,
        8'd21,8'd227,8'd173,8'd244,8'd119,8'd199,8'd128,8'd158
    };

    // f-function: key add, s-box layer, p-function
    function automatic logic [63:0] camb_f(input logic [63:0] din, input logic [63:0] key);
        logic [63:0] x;
        logic [7:0]  s;
        logic [7:0]  t0, t1, t2, t3, t4, t5, t6, t7;
        logic [7:0]  y0, y1, y2, y3, y4, y5, y6, y7;
        x  = din ^ key;
        t0 = SBOX1[x[63:56]];
        s  = SBOX1[x[55:48]];
        t1 = {s[6:0], s[7]};
        s  = SBOX1[x[47:40]];
        t2 = {s[0], s[7:1]};
        t3 = SBOX1[{x[38:32], x[39]}];
        s  = SBOX1[x[31:24]];
        t4 = {s[6:0], s[7]};
        s  = SBOX1[x[23:16]];
        t5 = {s[0], s[7:1]};
        t6 = SBOX1[{x[14:8], x[15]}];
        t7 = SBOX1[x[7:0]];
        y0 = t0 ^ t2 ^ t3 ^ t5 ^ t6 ^ t7;
        y1 = t0 ^ t1 ^ t3 ^ t4 ^ t6 ^ t7;
        y2 = t0 ^ t1 ^ t2 ^ t4 ^ t5 ^ t7;
        y3 = t1 ^ t2 ^ t3 ^ t4 ^ t5 ^ t6;
        y4 = t0 ^ t1 ^ t5 ^ t6 ^ t7;
        y5 = t1 ^ t2 ^ t4 ^ t6 ^ t7;
        y6 = t2 ^ t3 ^ t4 ^ t5 ^ t7;
        y7 = t0 ^ t3 ^ t4 ^ t5 ^ t6;
        return {y0, y1, y2, y3, y4, y5, y6, y7};
    endfunction

    function automatic logic [31:0] camb_rol1(input logic [31:0] v);
        return {v[30:0], v[31]};
    endfunction

    function automatic logic [63:0] camb_fl(input logic [63:0] x, input logic [63:0] k);
        logic [31:0] xl;
        logic [31:0] xr;
        xl = x[63:32];
        xr = x[31:0];
        xr = xr ^ camb_rol1(xl & k[63:32]);
        xl = xl ^ (xr | k[31:0]);
        return {xl, xr};
    endfunction

    function automatic logic [63:0] camb_fl_inv(input logic [63:0] y, input logic [63:0] k);
        logic [31:0] yl;
        logic [31:0] yr;
        yl = y[63:32];
        yr = y[31:0];
        yl = yl ^ (yr | k[31:0]);
        yr = yr ^ camb_rol1(yl & k[63:32]);
        return {yl, yr};
    endfunction

    // 128-bit left rotation by a constant amount in 1..127
    function automatic logic [127:0] camb_rot(input logic [127:0] v, input int unsigned n);
        return (v << n) | (v >> (128 - n));
    endfunction

endpackage

>>> src/camb_key_sched.sv
// ----------------------------------------------------------------------------
// camb_key_sched
// Key registers and key expansion: ka and kb through one shared f-function,
// one step per cycle, then fixed rotations into the subkey set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camb_key_sched (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [camb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [camb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_ready,
    output camb_pkg::t_subkeys              o_keys
);
    import camb_pkg::*;

    logic [63:0] r_key0, r_key1, r_key2, r_key3;
    logic [1:0]  r_size;
    t_ks_state   r_state, n_state;
    logic [63:0] r_d1, r_d2, n_d1, n_d2;
    logic [127:0] r_ka, r_kb, n_ka, n_kb;
    logic [63:0] kr0, kr1, f_in, f_sig, f_out;
    logic        short_key;
    logic [127:0] kl, kr;
    logic        cfg_hit;

    assign short_key = (r_size == KEY_SIZE_128);
    assign kr0 = short_key ? 64'd0 : r_key2;
    assign kr1 = short_key ? 64'd0 : ((r_size == KEY_SIZE_192) ? ~r_key2 : r_key3);
    assign kl  = {r_key0, r_key1};
    assign kr  = {kr0, kr1};
    assign cfg_hit = i_cfg_we && (i_cfg_index <= CFG_KEY_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
            r_size <= KEY_SIZE_128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_WORD_0: r_key0 <= i_cfg_data;
                CFG_KEY_WORD_1: r_key1 <= i_cfg_data;
                CFG_KEY_WORD_2: r_key2 <= i_cfg_data;
                CFG_KEY_WORD_3: r_key3 <= i_cfg_data;
                CFG_KEY_SIZE:   r_size <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1 <= n_d1;
        r_d2 <= n_d2;
        r_ka <= n_ka;
        r_kb <= n_kb;
    end

    assign f_out = camb_f(f_in, f_sig);

    always_comb begin
        n_state = r_state;
        n_d1    = r_d1;
        n_d2    = r_d2;
        n_ka    = r_ka;
        n_kb    = r_kb;
        f_in    = '0;
        f_sig   = '0;
        unique case (r_state)
            KS_LOAD: begin
                n_d1    = r_key0 ^ kr0;
                n_d2    = r_key1 ^ kr1;
                n_state = KS_F1;
            end
            KS_F1: begin
                f_in    = r_d1;
                f_sig   = SIGMA1;
                n_d2    = r_d2 ^ f_out;
                n_state = KS_F2;
            end
            KS_F2: begin
                f_in    = r_d2;
                f_sig   = SIGMA2;
                n_d1    = r_d1 ^ f_out;
                n_state = KS_F3;
            end
            KS_F3: begin
                f_in    = r_d1 ^ r_key0;
                f_sig   = SIGMA3;
                n_d1    = r_d1 ^ r_key0;
                n_d2    = r_d2 ^ r_key1 ^ f_out;
                n_state = KS_F4;
            end
            KS_F4: begin
                f_in    = r_d2;
                f_sig   = SIGMA4;
                n_d1    = r_d1 ^ f_out;
                n_ka    = {r_d1 ^ f_out, r_d2};
                n_state = KS_F5;
            end
            KS_F5: begin
                f_in    = r_d1 ^ kr0;
                f_sig   = SIGMA5;
                n_d1    = r_d1 ^ kr0;
                n_d2    = r_d2 ^ kr1 ^ f_out;
                n_state = KS_F6;
            end
            KS_F6: begin
                f_in    = r_d2;
                f_sig   = SIGMA6;
                n_d1    = r_d1 ^ f_out;
                n_kb    = {r_d1 ^ f_out, r_d2};
                n_state = KS_READY;
            end
            KS_READY: ;
            default: n_state = KS_LOAD;
        endcase
        // a key write restarts the expansion from the new registers
        if (cfg_hit) begin
            n_state = KS_LOAD;
        end
    end

    assign o_ready = (r_state == KS_READY);

    always_comb begin
        logic [127:0] t;
        t                = '0;
        o_keys           = '0;
        o_keys.short_key = short_key;
        o_keys.kw[0]     = r_key0;
        o_keys.kw[1]     = r_key1;
        if (short_key) begin
            o_keys.rk[0] = r_ka[127:64];
            o_keys.rk[1] = r_ka[63:0];
            {o_keys.rk[2], o_keys.rk[3]}   = camb_rot(kl, 15);
            {o_keys.rk[4], o_keys.rk[5]}   = camb_rot(r_ka, 15);
            {o_keys.lk[0], o_keys.lk[1]}   = camb_rot(r_ka, 30);
            {o_keys.rk[6], o_keys.rk[7]}   = camb_rot(kl, 45);
            t = camb_rot(r_ka, 45);
            o_keys.rk[8] = t[127:64];
            t = camb_rot(kl, 60);
            o_keys.rk[9] = t[63:0];
            {o_keys.rk[10], o_keys.rk[11]} = camb_rot(r_ka, 60);
            {o_keys.lk[2], o_keys.lk[3]}   = camb_rot(kl, 77);
            {o_keys.rk[12], o_keys.rk[13]} = camb_rot(kl, 94);
            {o_keys.rk[14], o_keys.rk[15]} = camb_rot(r_ka, 94);
            {o_keys.rk[16], o_keys.rk[17]} = camb_rot(kl, 111);
            {o_keys.kw[2], o_keys.kw[3]}   = camb_rot(r_ka, 111);
        end else begin
            o_keys.rk[0] = r_kb[127:64];
            o_keys.rk[1] = r_kb[63:0];
            {o_keys.rk[2], o_keys.rk[3]}   = camb_rot(kr, 15);
            {o_keys.rk[4], o_keys.rk[5]}   = camb_rot(r_ka, 15);
            {o_keys.lk[0], o_keys.lk[1]}   = camb_rot(kr, 30);
            {o_keys.rk[6], o_keys.rk[7]}   = camb_rot(r_kb, 30);
            {o_keys.rk[8], o_keys.rk[9]}   = camb_rot(kl, 45);
            {o_keys.rk[10], o_keys.rk[11]} = camb_rot(r_ka, 45);
            {o_keys.lk[2], o_keys.lk[3]}   = camb_rot(kl, 60);
            {o_keys.rk[12], o_keys.rk[13]} = camb_rot(kr, 60);
            {o_keys.rk[14], o_keys.rk[15]} = camb_rot(r_kb, 60);
            {o_keys.rk[16], o_keys.rk[17]} = camb_rot(kl, 77);
            {o_keys.lk[4], o_keys.lk[5]}   = camb_rot(r_ka, 77);
            {o_keys.rk[18], o_keys.rk[19]} = camb_rot(kr, 94);
            {o_keys.rk[20], o_keys.rk[21]} = camb_rot(r_ka, 94);
            {o_keys.rk[22], o_keys.rk[23]} = camb_rot(kl, 111);
            {o_keys.kw[2], o_keys.kw[3]}   = camb_rot(r_kb, 111);
        end
    end

endmodule

>>> src/camb_round.sv
// ----------------------------------------------------------------------------
// camb_round
// One pipeline stage: a single f-function on one half, an optional
// fl / fl-inverse layer, and the stage register with its valid bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camb_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic                 i_valid,
    input  camb_pkg::t_stage     i_data,
    input  camb_pkg::t_round_ctl i_ctl,
    output logic                 o_valid,
    output camb_pkg::t_stage     o_data
);
    import camb_pkg::*;

    logic        r_valid;
    t_stage      r_data, n_data;
    logic [63:0] f_out, x1, y1;

    assign f_out = camb_f(i_ctl.odd ? i_data.y : i_data.x, i_ctl.key);
    assign x1    = i_ctl.odd ? (i_data.x ^ f_out) : i_data.x;
    assign y1    = i_ctl.odd ? i_data.y : (i_data.y ^ f_out);

    always_comb begin
        n_data = i_data;
        if (!i_ctl.bypass) begin
            n_data.x = i_ctl.fl_en ? camb_fl(x1, i_ctl.fl_kx) : x1;
            n_data.y = i_ctl.fl_en ? camb_fl_inv(y1, i_ctl.fl_ky) : y1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> src/camellia_block_cipher.sv
// ----------------------------------------------------------------------------
// camellia_block_cipher: an accepted block passes the input register, the round stages
// and the output register; throughput one block per cycle through 24 round stages, one
// f-function each, while the output is not stalled; reset clears all valid bits; key
// expansion runs after reset and after each key write, and input is stalled until it is done
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camellia_block_cipher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [camb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [camb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  camb_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output camb_pkg::t_out_item             o_out_data
);
    import camb_pkg::*;

    t_subkeys    keys;
    logic        ks_ready;
    logic [25:0] w_v;
    logic [25:0] w_take;
    t_stage      w_st [NUM_ROUNDS+1];
    logic        r_v0;
    t_stage      r_st0, n_st0;
    logic        r_out_valid;
    t_out_item   r_out, n_out;

    camb_key_sched u_key_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ready     (ks_ready),
        .o_keys      (keys)
    );

    // a stage loads when it is empty or its content moves on
    assign w_take[25] = !r_out_valid || !i_out_stall;
    genvar s;
    generate
        for (s = 0; s < 25; s++) begin : g_take
            assign w_take[s] = !w_v[s] || w_take[s+1];
        end
    endgenerate

    assign o_in_stall = !w_take[0] || !ks_ready;

    // input whitening
    always_comb begin
        n_st0.mode = i_in_data.mode;
        if (i_in_data.mode) begin
            n_st0.x = i_in_data.block_hi ^ keys.kw[2];
            n_st0.y = i_in_data.block_lo ^ keys.kw[3];
        end else begin
            n_st0.x = i_in_data.block_hi ^ keys.kw[0];
            n_st0.y = i_in_data.block_lo ^ keys.kw[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_take[0]) begin
            r_v0 <= i_in_valid && ks_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take[0]) begin
            r_st0 <= n_st0;
        end
    end

    assign w_v[0]  = r_v0;
    assign w_st[0] = r_st0;

    genvar r;
    generate
        for (r = 0; r < NUM_ROUNDS; r++) begin : g_round
            localparam int DS  = (r <= 17) ? 17 - r : 0;
            localparam int DL  = 23 - r;
            localparam int M   = (r / 6 > 2) ? 2 : r / 6;
            localparam int DSL = (M <= 1) ? 1 - M : 0;
            localparam int DLL = 2 - M;
            t_round_ctl ctl;
            logic       dec;

            assign dec = w_st[r].mode;

            always_comb begin
                ctl.key = !dec ? keys.rk[r]
                        : (keys.short_key ? keys.rk[DS] : keys.rk[DL]);
                ctl.fl_kx = !dec ? keys.lk[2*M]
                          : (keys.short_key ? keys.lk[2*DSL+1] : keys.lk[2*DLL+1]);
                ctl.fl_ky = !dec ? keys.lk[2*M+1]
                          : (keys.short_key ? keys.lk[2*DSL] : keys.lk[2*DLL]);
                ctl.fl_en = (r == 5 || r == 11) ? 1'b1
                          : ((r == 17) ? !keys.short_key : 1'b0);
                ctl.odd   = (r % 2 == 1);
                // the last six rounds only run for 192 and 256 bit keys
                ctl.bypass = (r >= 18) ? keys.short_key : 1'b0;
            end

            camb_round u_round (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_take  (w_take[r+1]),
                .i_valid (w_v[r]),
                .i_data  (w_st[r]),
                .i_ctl   (ctl),
                .o_valid (w_v[r+1]),
                .o_data  (w_st[r+1])
            );
        end
    endgenerate

    // output whitening, result is (y, x)
    always_comb begin
        if (w_st[NUM_ROUNDS].mode) begin
            n_out.result_hi = w_st[NUM_ROUNDS].y ^ keys.kw[0];
            n_out.result_lo = w_st[NUM_ROUNDS].x ^ keys.kw[1];
        end else begin
            n_out.result_hi = w_st[NUM_ROUNDS].y ^ keys.kw[2];
            n_out.result_lo = w_st[NUM_ROUNDS].x ^ keys.kw[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take[25]) begin
            r_out_valid <= w_v[24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take[25]) begin
            r_out <= n_out;
        end
    end

    assign w_v[25]     = r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> test/tb_camellia_block_cipher.sv
// ----------------------------------------------------------------------------
// tb_camellia_block_cipher
// Self-checking bench: key setups of every size, blocks in both directions,
// random idling on both channels, results checked against an in-bench cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_camellia_block_cipher;
    import camb_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_item               i_in_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_item              o_out_data;

    camellia_block_cipher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // bench copy of the key registers and the expanded schedule
    logic [63:0] key_reg [4];
    logic [1:0]  key_len;
    logic [63:0] white_k [4];
    logic [63:0] rnd_k   [24];
    logic [63:0] lay_k   [6];
    bit          sched_ok;

    t_in_item  blocks_pending[$];
    t_out_item cipher_expected[$];
    int        errors;
    bit        in_took;
    bit        quiet;
    bit        hold_req;
    int        hold_left;
    int        stall_left;
    int        gap_left;

    function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [63:0] f_mix(input logic [63:0] din, input logic [63:0] k);
        logic [63:0] x;
        logic [7:0]  t [8];
        logic [7:0]  y [8];
        x = din ^ k;
        for (int i = 0; i < 8; i++) t[i] = x[63-8*i -: 8];
        t[0] = SBOX1[t[0]];
        t[1] = rol8(SBOX1[t[1]], 1);
        t[2] = rol8(SBOX1[t[2]], 7);
        t[3] = SBOX1[rol8(t[3], 1)];
        t[4] = rol8(SBOX1[t[4]], 1);
        t[5] = rol8(SBOX1[t[5]], 7);
        t[6] = SBOX1[rol8(t[6], 1)];
        t[7] = SBOX1[t[7]];
        y[0] = t[0] ^ t[2] ^ t[3] ^ t[5] ^ t[6] ^ t[7];
        y[1] = t[0] ^ t[1] ^ t[3] ^ t[4] ^ t[6] ^ t[7];
        y[2] = t[0] ^ t[1] ^ t[2] ^ t[4] ^ t[5] ^ t[7];
        y[3] = t[1] ^ t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[6];
        y[4] = t[0] ^ t[1] ^ t[5] ^ t[6] ^ t[7];
        y[5] = t[1] ^ t[2] ^ t[4] ^ t[6] ^ t[7];
        y[6] = t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[7];
        y[7] = t[0] ^ t[3] ^ t[4] ^ t[5] ^ t[6];
        return {y[0], y[1], y[2], y[3], y[4], y[5], y[6], y[7]};
    endfunction

    function automatic logic [63:0] fl_layer(input logic [63:0] x, input logic [63:0] k);
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] a;
        l = x[63:32];
        r = x[31:0];
        a = l & k[63:32];
        r = r ^ {a[30:0], a[31]};
        l = l ^ (r | k[31:0]);
        return {l, r};
    endfunction

    function automatic logic [63:0] fl_layer_inv(input logic [63:0] x, input logic [63:0] k);
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] a;
        l = x[63:32];
        r = x[31:0];
        l = l ^ (r | k[31:0]);
        a = l & k[63:32];
        r = r ^ {a[30:0], a[31]};
        return {l, r};
    endfunction

    function automatic logic [127:0] rotl128(input logic [127:0] v, input int n);
        return (v << n) | (v >> (128 - n));
    endfunction

    function automatic void build_schedule();
        logic [63:0]  kl0, kl1, kr0, kr1, d1, d2;
        logic [127:0] kl, kr, ka, kb, t;
        bit           short_key;
        short_key = (key_len == KEY_SIZE_128);
        kl0 = key_reg[0];
        kl1 = key_reg[1];
        kr0 = '0;
        kr1 = '0;
        if (!short_key) begin
            kr0 = key_reg[2];
            kr1 = (key_len == KEY_SIZE_192) ? ~key_reg[2] : key_reg[3];
        end
        d1 = kl0 ^ kr0;
        d2 = kl1 ^ kr1;
        d2 ^= f_mix(d1, SIGMA1);
        d1 ^= f_mix(d2, SIGMA2);
        d1 ^= kl0;
        d2 ^= kl1;
        d2 ^= f_mix(d1, SIGMA3);
        d1 ^= f_mix(d2, SIGMA4);
        kl = {kl0, kl1};
        kr = {kr0, kr1};
        ka = {d1, d2};
        foreach (rnd_k[i]) rnd_k[i] = '0;
        foreach (lay_k[i]) lay_k[i] = '0;
        white_k[0] = kl0;
        white_k[1] = kl1;
        if (short_key) begin
            {rnd_k[0], rnd_k[1]}     = ka;
            {rnd_k[2], rnd_k[3]}     = rotl128(kl, 15);
            {rnd_k[4], rnd_k[5]}     = rotl128(ka, 15);
            {lay_k[0], lay_k[1]}     = rotl128(ka, 30);
            {rnd_k[6], rnd_k[7]}     = rotl128(kl, 45);
            t = rotl128(ka, 45);
            rnd_k[8] = t[127:64];
            t = rotl128(kl, 60);
            rnd_k[9] = t[63:0];
            {rnd_k[10], rnd_k[11]}   = rotl128(ka, 60);
            {lay_k[2], lay_k[3]}     = rotl128(kl, 77);
            {rnd_k[12], rnd_k[13]}   = rotl128(kl, 94);
            {rnd_k[14], rnd_k[15]}   = rotl128(ka, 94);
            {rnd_k[16], rnd_k[17]}   = rotl128(kl, 111);
            {white_k[2], white_k[3]} = rotl128(ka, 111);
        end else begin
            d1 = ka[127:64] ^ kr0;
            d2 = ka[63:0] ^ kr1;
            d2 ^= f_mix(d1, SIGMA5);
            d1 ^= f_mix(d2, SIGMA6);
            kb = {d1, d2};
            {rnd_k[0], rnd_k[1]}     = kb;
            {rnd_k[2], rnd_k[3]}     = rotl128(kr, 15);
            {rnd_k[4], rnd_k[5]}     = rotl128(ka, 15);
            {lay_k[0], lay_k[1]}     = rotl128(kr, 30);
            {rnd_k[6], rnd_k[7]}     = rotl128(kb, 30);
            {rnd_k[8], rnd_k[9]}     = rotl128(kl, 45);
            {rnd_k[10], rnd_k[11]}   = rotl128(ka, 45);
            {lay_k[2], lay_k[3]}     = rotl128(kl, 60);
            {rnd_k[12], rnd_k[13]}   = rotl128(kr, 60);
            {rnd_k[14], rnd_k[15]}   = rotl128(kb, 60);
            {rnd_k[16], rnd_k[17]}   = rotl128(kl, 77);
            {lay_k[4], lay_k[5]}     = rotl128(ka, 77);
            {rnd_k[18], rnd_k[19]}   = rotl128(kr, 94);
            {rnd_k[20], rnd_k[21]}   = rotl128(ka, 94);
            {rnd_k[22], rnd_k[23]}   = rotl128(kl, 111);
            {white_k[2], white_k[3]} = rotl128(kb, 111);
        end
        sched_ok = 1'b1;
    endfunction

    function automatic t_out_item cipher_block(input t_in_item blk);
        logic [63:0] x, y;
        int          pairs, p, j;
        t_out_item   res;
        if (!sched_ok) build_schedule();
        pairs = (key_len == KEY_SIZE_128) ? 9 : 12;
        x = blk.block_hi;
        y = blk.block_lo;
        if (!blk.mode) begin
            x ^= white_k[0];
            y ^= white_k[1];
            for (int i = 0; i < pairs; i++) begin
                p = 2 * i;
                y ^= f_mix(x, rnd_k[p]);
                x ^= f_mix(y, rnd_k[p+1]);
                if (i % 3 == 2 && i + 1 < pairs) begin
                    j = 2 * (i / 3);
                    x = fl_layer(x, lay_k[j]);
                    y = fl_layer_inv(y, lay_k[j+1]);
                end
            end
            y ^= white_k[2];
            x ^= white_k[3];
        end else begin
            x ^= white_k[2];
            y ^= white_k[3];
            for (int i = pairs; i > 0; i--) begin
                p = 2 * (i - 1);
                y ^= f_mix(x, rnd_k[p+1]);
                x ^= f_mix(y, rnd_k[p]);
                if ((i - 1) % 3 == 0 && i > 1) begin
                    j = 2 * ((i - 1) / 3 - 1);
                    x = fl_layer(x, lay_k[j+1]);
                    y = fl_layer_inv(y, lay_k[j]);
                end
            end
            x ^= white_k[1];
            y ^= white_k[0];
        end
        res.result_hi = y;
        res.result_lo = x;
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // sample at the rising edge: accept blocks, check results
    always @(posedge i_clk) begin
        t_out_item want;
        in_took = i_rst_n && i_in_valid && !o_in_stall;
        if (in_took) cipher_expected.push_back(cipher_block(i_in_data));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cipher_expected.size() == 0) begin
                $error("unexpected result transaction %h", o_out_data);
                errors++;
            end else begin
                want = cipher_expected.pop_front();
                if (o_out_data.result_hi !== want.result_hi) begin
                    $error("result_hi expected %h actual %h", want.result_hi,
                           o_out_data.result_hi);
                    errors++;
                end
                if (o_out_data.result_lo !== want.result_lo) begin
                    $error("result_lo expected %h actual %h", want.result_lo,
                           o_out_data.result_lo);
                    errors++;
                end
            end
        end
    end

    // block driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (blocks_pending.size() > 0 && (quiet || $urandom_range(0, 7) != 0)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= blocks_pending.pop_front();
            end else begin
                if (blocks_pending.size() > 0) gap_left = $urandom_range(0, 7);
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 300;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= CFG_KEY_WORD_3) begin
            key_reg[idx[1:0]] = val;
            sched_ok          = 1'b0;
        end else if (idx == CFG_KEY_SIZE) begin
            key_len  = val[1:0];
            sched_ok = 1'b0;
        end
    endtask

    task automatic load_key(input logic [63:0] k0, k1, k2, k3, input logic [1:0] len);
        put_reg(CFG_KEY_WORD_0, k0);
        put_reg(CFG_KEY_WORD_1, k1);
        put_reg(CFG_KEY_WORD_2, k2);
        put_reg(CFG_KEY_WORD_3, k3);
        put_reg(CFG_KEY_SIZE, {$urandom, $urandom} & ~64'd3 | 64'(len));
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_block(input logic m, input logic [63:0] hi, lo);
        t_in_item b;
        b.mode     = m;
        b.block_hi = hi;
        b.block_lo = lo;
        blocks_pending.push_back(b);
    endtask

    task automatic push_random(input int n);
        repeat (n) push_block(1'($urandom), rand64(), rand64());
    endtask

    // sender pause until every result is back and the pipeline has emptied
    task automatic drain();
        while (blocks_pending.size() > 0 || i_in_valid || cipher_expected.size() > 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    initial begin
        t_out_item ct;
        t_in_item  pt;
        errors      = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        hold_left   = 0;
        stall_left  = 0;
        gap_left    = 0;
        in_took     = 1'b0;
        foreach (key_reg[i]) key_reg[i] = '0;
        key_len     = KEY_SIZE_128;
        sched_ok    = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_KEY_WORD_0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // schedule from the all-zero reset key
        for (int m = 0; m < 2; m++) begin
            push_block(m[0], '0, '0);
            push_block(m[0], '1, '1);
            push_block(m[0], 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
            push_block(m[0], 64'h8000000000000000, 64'h0000000000000001);
        end
        drain();

        // standard 128-bit key, then decrypt its ciphertext
        load_key(64'h0123456789abcdef, 64'hfedcba9876543210, '1, '1, KEY_SIZE_128);
        pt.mode     = 1'b0;
        pt.block_hi = 64'h0123456789abcdef;
        pt.block_lo = 64'hfedcba9876543210;
        ct = cipher_block(pt);
        push_block(1'b0, pt.block_hi, pt.block_lo);
        push_block(1'b1, ct.result_hi, ct.result_lo);
        push_random(200);
        drain();

        // 192-bit key: last word is ignored; receiver holds off long
        load_key(rand64(), rand64(), {$urandom, $urandom}, {$urandom, $urandom}, KEY_SIZE_192);
        @(posedge i_clk);
        hold_req = 1'b1;
        push_random(250);
        drain();

        load_key('1, '1, '1, '1, 2'd2);
        push_random(200);
        drain();

        // size code three acts as 256, writes past the last register are ignored
        load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, 2'd3);
        put_reg(3'd5, {$urandom, $urandom});
        put_reg(3'd6, {$urandom, $urandom});
        put_reg(3'd7, '1);
        push_random(250);
        drain();

        load_key('0, '0, '0, '0, KEY_SIZE_128);
        push_random(200);
        drain();

        // closing stretch without any idling
        load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, 2'd2);
        quiet = 1'b1;
        push_random(290);
        drain();

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
